[src/hbrd_pkg.sv]
// Shared types, constants and register codes of the heart beat rate detector.
package hbrd_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int PERIOD_W   = 8;
    localparam int MS_W       = 16;
    localparam int RATE_W     = 8;
    localparam int CLOCK_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int DIV_W      = 16;
    localparam int DIV_CNT_W  = 5;

    localparam logic [DIV_W-1:0]    RATE_NUMERATOR = 16'd60000;
    localparam logic [MS_W-1:0]     INTERVAL_MAX   = 16'hFFFF;
    localparam logic [MS_W-1:0]     INTERVAL_RESET = 16'd600;

    localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET  = 12'd2380;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET     = 8'd5;
    localparam logic [MS_W-1:0]     REFRACTORY_RESET = 16'd333;
    localparam logic [MS_W-1:0]     TIMEOUT_RESET    = 16'd2000;
    localparam logic [RATE_W-1:0]   RATE_MIN_RESET   = 8'd45;
    localparam logic [RATE_W-1:0]   RATE_MAX_RESET   = 8'd90;
    localparam logic [RATE_W-1:0]   DOUBLE_MAX_RESET = 8'd180;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD       = 3'd0,
        REG_SAMPLE_PERIOD   = 3'd1,
        REG_REFRACTORY      = 3'd2,
        REG_TIMEOUT         = 3'd3,
        REG_RATE_MIN        = 3'd4,
        REG_RATE_MAX        = 3'd5,
        REG_DOUBLE_RATE_MAX = 3'd6
    } hbrd_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ELAPSED,
        ST_EVAL,
        ST_RATE_START,
        ST_RATE_WAIT,
        ST_CLASSIFY,
        ST_PUSH,
        ST_AVG_START,
        ST_AVG_WAIT,
        ST_FINISH
    } hbrd_state_t;

    typedef struct packed {
        logic load;
        logic elapsed;
        logic eval;
        logic div_start;
        logic div_avg;
        logic classify;
        logic push;
        logic avg_load;
        logic finish;
    } hbrd_cmd_t;

    typedef struct packed {
        logic beat;
        logic fin_nz;
        logic timeout;
        logic div_done;
        logic out_free;
    } hbrd_stat_t;

endpackage

[src/hbrd_if.sv]
// Stream interfaces for the sample channel and the result channel.
interface hbrd_sample_if
    import hbrd_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface hbrd_result_if
    import hbrd_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [RATE_W-1:0] rate_bpm;
    logic              rate_updated;
    logic              beat_seen;
    logic              in_pulse;
    logic [MS_W-1:0]   interval_ms;

    modport source (output valid, output rate_bpm, output rate_updated, output beat_seen,
                    output in_pulse, output interval_ms, input ready);
    modport sink   (input valid, input rate_bpm, input rate_updated, input beat_seen,
                    input in_pulse, input interval_ms, output ready);
endinterface

[src/hbrd_divider.sv]
// Restoring divider that produces one quotient bit per cycle.
module hbrd_divider
    import hbrd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic [DIV_W-1:0] quotient,
    output logic             done
);

    logic [DIV_W-1:0]     rem_reg, rem_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [DIV_W-1:0]     dvs_reg, dvs_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_W:0]       trial;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[DIV_W-1]} - {1'b0, dvs_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            // A clear borrow means the shifted remainder covers the divisor.
            if (!trial[DIV_W])
            begin
                rem_next = trial[DIV_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[DIV_W-2:0], quo_reg[DIV_W-1]};
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

[src/hbrd_ctrl.sv]
// Sequencing state machine of the heart beat rate detector.
module hbrd_ctrl
    import hbrd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  hbrd_stat_t stat,
    output logic       in_ready,
    output hbrd_cmd_t  cmd
);

    hbrd_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_ELAPSED;
                end
            end
            ST_ELAPSED:
            begin
                cmd.elapsed = 1'b1;
                state_next  = ST_EVAL;
            end
            ST_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = stat.beat ? ST_RATE_START : ST_FINISH;
            end
            ST_RATE_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_RATE_WAIT;
            end
            ST_RATE_WAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_CLASSIFY;
                end
            end
            ST_CLASSIFY:
            begin
                // A timeout on the same tick wipes the history anyway.
                cmd.classify = 1'b1;
                state_next   = (stat.fin_nz && !stat.timeout) ? ST_PUSH : ST_FINISH;
            end
            ST_PUSH:
            begin
                cmd.push   = 1'b1;
                state_next = ST_AVG_START;
            end
            ST_AVG_START:
            begin
                cmd.div_start = 1'b1;
                cmd.div_avg   = 1'b1;
                state_next    = ST_AVG_WAIT;
            end
            ST_AVG_WAIT:
            begin
                cmd.div_avg = 1'b1;
                if (stat.div_done)
                begin
                    cmd.avg_load = 1'b1;
                    state_next   = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[src/hbrd_datapath.sv]
// Registers, rate history and arithmetic of the heart beat rate detector.
module hbrd_datapath
    import hbrd_pkg::*;
#(
    parameter int HISTORY_DEPTH = 20
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  hbrd_cmd_t             cmd,
    output hbrd_stat_t            stat,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    input  logic [SAMPLE_W-1:0]   sample,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [RATE_W-1:0]     rate_bpm,
    output logic                  rate_updated,
    output logic                  beat_seen,
    output logic                  in_pulse,
    output logic [MS_W-1:0]       interval_ms
);

    localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W = $clog2(HISTORY_DEPTH * 255 + 1);

    // Configuration registers.
    logic [SAMPLE_W-1:0] thr_reg, thr_next;
    logic [PERIOD_W-1:0] period_reg, period_next;
    logic [MS_W-1:0]     refr_reg, refr_next;
    logic [MS_W-1:0]     tmo_reg, tmo_next;
    logic [RATE_W-1:0]   rmin_reg, rmin_next;
    logic [RATE_W-1:0]   rmax_reg, rmax_next;
    logic [RATE_W-1:0]   dmax_reg, dmax_next;

    // Detector state.
    logic [CLOCK_W-1:0]  clock_reg, clock_next;
    logic [CLOCK_W-1:0]  last_beat_reg, last_beat_next;
    logic                pulse_reg, pulse_next;
    logic [MS_W-1:0]     interval_reg, interval_next;
    logic [IDX_W-1:0]    wp_reg, wp_next;
    logic [CNT_W-1:0]    filled_reg, filled_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [RATE_W-1:0]   avg_reg, avg_next;
    logic                out_valid_reg, out_valid_next;

    // Per-item working values.
    logic [SAMPLE_W-1:0] sample_reg, sample_next;
    logic [CLOCK_W-1:0]  elapsed_reg, elapsed_next;
    logic                beat_reg, beat_next;
    logic                timeout_reg, timeout_next;
    logic                updated_reg, updated_next;
    logic [RATE_W-1:0]   fin_reg, fin_next;
    logic [RATE_W-1:0]   old_reg;

    // Output holding registers.
    logic [RATE_W-1:0]   out_rate_reg, out_rate_next;
    logic                out_upd_reg, out_upd_next;
    logic                out_beat_reg, out_beat_next;
    logic                out_pulse_reg, out_pulse_next;
    logic [MS_W-1:0]     out_int_reg, out_int_next;

    logic [RATE_W-1:0]   hist_mem [HISTORY_DEPTH];

    logic [DIV_W-1:0]    div_dividend, div_divisor, div_quo;
    logic                div_done;
    logic                beat_now;
    logic                full;
    logic [RATE_W-1:0]   fin;

    assign div_dividend = cmd.div_avg ? DIV_W'(sum_reg) : RATE_NUMERATOR;
    assign div_divisor  = cmd.div_avg ? DIV_W'(filled_reg) : interval_reg;

    hbrd_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quo),
        .done     (div_done)
    );

    assign beat_now = (sample_reg > thr_reg) && !pulse_reg
                      && (elapsed_reg > CLOCK_W'(refr_reg));
    assign full     = (filled_reg == CNT_W'(HISTORY_DEPTH));

    // Double counts are halved, real rates kept, the rest dropped.
    always_comb
    begin
        fin = '0;
        if ((div_quo > DIV_W'(rmax_reg)) && (div_quo < DIV_W'(dmax_reg)))
        begin
            fin = div_quo[RATE_W:1];
        end
        else if ((div_quo >= DIV_W'(rmin_reg)) && (div_quo <= DIV_W'(rmax_reg)))
        begin
            fin = div_quo[RATE_W-1:0];
        end
    end

    always_comb
    begin
        thr_next       = thr_reg;
        period_next    = period_reg;
        refr_next      = refr_reg;
        tmo_next       = tmo_reg;
        rmin_next      = rmin_reg;
        rmax_next      = rmax_reg;
        dmax_next      = dmax_reg;
        clock_next     = clock_reg;
        last_beat_next = last_beat_reg;
        pulse_next     = pulse_reg;
        interval_next  = interval_reg;
        wp_next        = wp_reg;
        filled_next    = filled_reg;
        sum_next       = sum_reg;
        avg_next       = avg_reg;
        out_valid_next = out_valid_reg;
        sample_next    = sample_reg;
        elapsed_next   = elapsed_reg;
        beat_next      = beat_reg;
        timeout_next   = timeout_reg;
        updated_next   = updated_reg;
        fin_next       = fin_reg;
        out_rate_next  = out_rate_reg;
        out_upd_next   = out_upd_reg;
        out_beat_next  = out_beat_reg;
        out_pulse_next = out_pulse_reg;
        out_int_next   = out_int_reg;

        if (wr_en)
        begin
            unique case (wr_index)
                REG_THRESHOLD:       thr_next    = wr_data[SAMPLE_W-1:0];
                REG_SAMPLE_PERIOD:   period_next = wr_data[PERIOD_W-1:0];
                REG_REFRACTORY:      refr_next   = wr_data[MS_W-1:0];
                REG_TIMEOUT:         tmo_next    = wr_data[MS_W-1:0];
                REG_RATE_MIN:        rmin_next   = wr_data[RATE_W-1:0];
                REG_RATE_MAX:        rmax_next   = wr_data[RATE_W-1:0];
                REG_DOUBLE_RATE_MAX: dmax_next   = wr_data[RATE_W-1:0];
                default:             ;
            endcase
        end

        if (cmd.load)
        begin
            sample_next = sample;
            clock_next  = clock_reg + CLOCK_W'(period_reg);
        end

        if (cmd.elapsed)
        begin
            elapsed_next = clock_reg - last_beat_reg;
        end

        if (cmd.eval)
        begin
            beat_next    = beat_now;
            timeout_next = elapsed_reg > CLOCK_W'(tmo_reg);
            updated_next = 1'b0;
            if (beat_now)
            begin
                pulse_next     = 1'b1;
                last_beat_next = clock_reg;
                interval_next  = (elapsed_reg[CLOCK_W-1:MS_W] != '0)
                                 ? INTERVAL_MAX : elapsed_reg[MS_W-1:0];
            end
            else if ((sample_reg < thr_reg) && pulse_reg)
            begin
                pulse_next = 1'b0;
            end
        end

        if (cmd.classify)
        begin
            fin_next = fin;
            if (fin != '0)
            begin
                updated_next = 1'b1;
            end
        end

        if (cmd.push)
        begin
            if (full)
            begin
                sum_next = sum_reg - SUM_W'(old_reg) + SUM_W'(fin_reg);
            end
            else
            begin
                sum_next    = sum_reg + SUM_W'(fin_reg);
                filled_next = filled_reg + 1'b1;
            end
            wp_next = (wp_reg == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
        end

        if (cmd.avg_load)
        begin
            avg_next = div_quo[RATE_W-1:0];
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
            out_rate_next  = timeout_reg ? '0 : avg_reg;
            out_upd_next   = updated_reg || (timeout_reg && (avg_reg != '0));
            out_beat_next  = beat_reg;
            out_pulse_next = pulse_reg;
            out_int_next   = interval_reg;
            if (timeout_reg)
            begin
                wp_next     = '0;
                filled_next = '0;
                sum_next    = '0;
                avg_next    = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg       <= THRESHOLD_RESET;
            period_reg    <= PERIOD_RESET;
            refr_reg      <= REFRACTORY_RESET;
            tmo_reg       <= TIMEOUT_RESET;
            rmin_reg      <= RATE_MIN_RESET;
            rmax_reg      <= RATE_MAX_RESET;
            dmax_reg      <= DOUBLE_MAX_RESET;
            clock_reg     <= '0;
            last_beat_reg <= '0;
            pulse_reg     <= 1'b0;
            interval_reg  <= INTERVAL_RESET;
            wp_reg        <= '0;
            filled_reg    <= '0;
            sum_reg       <= '0;
            avg_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            thr_reg       <= thr_next;
            period_reg    <= period_next;
            refr_reg      <= refr_next;
            tmo_reg       <= tmo_next;
            rmin_reg      <= rmin_next;
            rmax_reg      <= rmax_next;
            dmax_reg      <= dmax_next;
            clock_reg     <= clock_next;
            last_beat_reg <= last_beat_next;
            pulse_reg     <= pulse_next;
            interval_reg  <= interval_next;
            wp_reg        <= wp_next;
            filled_reg    <= filled_next;
            sum_reg       <= sum_next;
            avg_reg       <= avg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg    <= sample_next;
        elapsed_reg   <= elapsed_next;
        beat_reg      <= beat_next;
        timeout_reg   <= timeout_next;
        updated_reg   <= updated_next;
        fin_reg       <= fin_next;
        out_rate_reg  <= out_rate_next;
        out_upd_reg   <= out_upd_next;
        out_beat_reg  <= out_beat_next;
        out_pulse_reg <= out_pulse_next;
        out_int_reg   <= out_int_next;
    end

    // The entry being replaced is read before the push overwrites it.
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            hist_mem[wp_reg] <= fin_reg;
        end
        if (cmd.classify)
        begin
            old_reg <= hist_mem[wp_reg];
        end
    end

    assign stat.beat     = beat_now;
    assign stat.fin_nz   = (fin != '0);
    assign stat.timeout  = timeout_reg;
    assign stat.div_done = div_done;
    assign stat.out_free = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign rate_bpm     = out_rate_reg;
    assign rate_updated = out_upd_reg;
    assign beat_seen    = out_beat_reg;
    assign in_pulse     = out_pulse_reg;
    assign interval_ms  = out_int_reg;

endmodule

[src/heart_beat_rate_detector_unit.sv]
// Top level of the heart beat rate detector: controller, datapath and ports.
//
//  Channel     Direction  Handshake       Contents
//  ---------   ---------  --------------  -------------------------------------------
//  sample_ch   sink       valid / ready   sample, 12-bit converter reading
//  result_ch   source     valid / ready   rate_bpm, rate_updated, beat_seen,
//                                         in_pulse, interval_ms
//  wr_*        sink       wr_en only      wr_index selects a register, wr_data holds it
//
// One item is worked on at a time: a new sample is accepted only in the idle step.
// A tick without a beat runs no division; a beat whose rate is dropped runs one, and
// a beat whose rate enters the history runs two. Each is a 16-step pass of the shared
// restoring divider: one for 60000 / interval, one for the mean.
// Reset sets configuration and detector state to defaults and empties the history;
// its memory is not cleared, as only entries written since the last clear are read.
// A result waits in the output register while the next item is already accepted;
// the block then holds in its last step until the result has been taken.
module heart_beat_rate_detector_unit
    import hbrd_pkg::*;
#(
    parameter int HISTORY_DEPTH = 20
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    hbrd_sample_if.sink           sample_ch,
    hbrd_result_if.source         result_ch,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data
);

    hbrd_cmd_t  cmd;
    hbrd_stat_t stat;
    logic       ready;

    // The controller sequences each tick: clock advance, elapsed time, beat test,
    // rate division, history update, mean division and the result hand-off.
    hbrd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample_ch.valid),
        .stat     (stat),
        .in_ready (ready),
        .cmd      (cmd)
    );

    assign sample_ch.ready = ready;

    // The datapath holds the configuration, the detector state, the rate ring
    // and the output register, and owns the divider.
    hbrd_datapath #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data),
        .sample       (sample_ch.sample),
        .out_ready    (result_ch.ready),
        .out_valid    (result_ch.valid),
        .rate_bpm     (result_ch.rate_bpm),
        .rate_updated (result_ch.rate_updated),
        .beat_seen    (result_ch.beat_seen),
        .in_pulse     (result_ch.in_pulse),
        .interval_ms  (result_ch.interval_ms)
    );

endmodule

[verif/tb_heart_beat_rate_detector_unit.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the heart beat rate detector with its own rate predictor.
module tb_heart_beat_rate_detector_unit;
    import hbrd_pkg::*;

    // The ring depth of the block under test. The predictor uses the same figure.
    localparam int RING_DEPTH = 20;

    // Register index past the last real register. The block must ignore writes to it.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    // After the last result we wait longer than a beat whose rate enters the history
    // takes, before touching the registers or ending.
    localparam int QUIET_CYCLES = 64;

    // Length of the single long stall of the result side, in cycles.
    localparam int LONG_STALL = 400;

    // Hard stop.
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [RATE_W-1:0] rate_bpm;
        logic              rate_updated;
        logic              beat_seen;
        logic              in_pulse;
        logic [MS_W-1:0]   interval_ms;
    } rate_result_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] threshold;
        logic [PERIOD_W-1:0] period_ms;
        logic [MS_W-1:0]     refractory_ms;
        logic [MS_W-1:0]     timeout_ms;
        logic [RATE_W-1:0]   rate_min;
        logic [RATE_W-1:0]   rate_max;
        logic [RATE_W-1:0]   double_max;
    } detector_cfg_t;

    // Scoreboard: holds a copy of the detector state and configuration, works out
    // the result of every accepted sample and checks the results in order.
    class rate_scoreboard;
        int unsigned        threshold;
        int unsigned        period_ms;
        int unsigned        refractory_ms;
        int unsigned        timeout_ms;
        int unsigned        rate_min;
        int unsigned        rate_max;
        int unsigned        double_max;

        logic [CLOCK_W-1:0] clock_ms;
        logic [CLOCK_W-1:0] last_beat_ms;
        bit                 pulse_on;
        logic [MS_W-1:0]    last_interval;
        logic [RATE_W-1:0]  ring [RING_DEPTH];
        int unsigned        ring_pos;
        int unsigned        ring_fill;
        int unsigned        avg_rate;

        rate_result_t       rates_due[$];
        int unsigned        mismatches;

        function new();
            threshold     = 32'(THRESHOLD_RESET);
            period_ms     = 32'(PERIOD_RESET);
            refractory_ms = 32'(REFRACTORY_RESET);
            timeout_ms    = 32'(TIMEOUT_RESET);
            rate_min      = 32'(RATE_MIN_RESET);
            rate_max      = 32'(RATE_MAX_RESET);
            double_max    = 32'(DOUBLE_MAX_RESET);
            clock_ms      = '0;
            last_beat_ms  = '0;
            pulse_on      = 1'b0;
            last_interval = INTERVAL_RESET;
            avg_rate      = 0;
            mismatches    = 0;
            clear_ring();
        endfunction

        function void clear_ring();
            for (int k = 0; k < RING_DEPTH; k++)
            begin
                ring[k] = '0;
            end
            ring_pos  = 0;
            ring_fill = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_THRESHOLD:       threshold     = 32'(data[SAMPLE_W-1:0]);
                REG_SAMPLE_PERIOD:   period_ms     = 32'(data[PERIOD_W-1:0]);
                REG_REFRACTORY:      refractory_ms = 32'(data[MS_W-1:0]);
                REG_TIMEOUT:         timeout_ms    = 32'(data[MS_W-1:0]);
                REG_RATE_MIN:        rate_min      = 32'(data[RATE_W-1:0]);
                REG_RATE_MAX:        rate_max      = 32'(data[RATE_W-1:0]);
                REG_DOUBLE_RATE_MAX: double_max    = 32'(data[RATE_W-1:0]);
                default:             ;
            endcase
        endfunction

        function void note_sample(logic [SAMPLE_W-1:0] sample);
            logic [CLOCK_W-1:0] elapsed;
            int unsigned        inst;
            int unsigned        kept;
            int unsigned        sum;
            bit                 beat;
            bit                 updated;
            rate_result_t       res;
            beat    = 1'b0;
            updated = 1'b0;
            clock_ms = clock_ms + period_ms;
            // Elapsed time is taken before the beat moves the last beat mark; the
            // timeout below uses this same value.
            elapsed = clock_ms - last_beat_ms;
            if (sample > threshold && !pulse_on && elapsed > refractory_ms)
            begin
                beat          = 1'b1;
                pulse_on      = 1'b1;
                last_interval = (elapsed > INTERVAL_MAX) ? INTERVAL_MAX : elapsed[MS_W-1:0];
                last_beat_ms  = clock_ms;
                inst          = 32'(RATE_NUMERATOR / last_interval);
                kept          = 0;
                // Bands are used exactly as written, so crossed bounds never match.
                if (inst > rate_max && inst < double_max)
                    kept = inst / 2;
                else if (inst >= rate_min && inst <= rate_max)
                    kept = inst;
                if (kept > 0)
                begin
                    ring[ring_pos] = kept[RATE_W-1:0];
                    ring_pos = (ring_pos + 1) % RING_DEPTH;
                    if (ring_fill < RING_DEPTH)
                        ring_fill++;
                    sum = 0;
                    for (int k = 0; k < ring_fill; k++)
                    begin
                        sum += 32'(ring[k]);
                    end
                    avg_rate = sum / ring_fill;
                    updated  = 1'b1;
                end
            end
            if (sample < threshold && pulse_on)
                pulse_on = 1'b0;
            if (elapsed > timeout_ms)
            begin
                clear_ring();
                if (avg_rate != 0)
                begin
                    avg_rate = 0;
                    updated  = 1'b1;
                end
            end
            res.rate_bpm     = avg_rate[RATE_W-1:0];
            res.rate_updated = updated;
            res.beat_seen    = beat;
            res.in_pulse     = pulse_on;
            res.interval_ms  = last_interval;
            rates_due.push_back(res);
        endfunction

        function void check_result(rate_result_t got);
            rate_result_t want;
            bit           bad;
            if (rates_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result with no sample pending: %0d/%0b/%0b/%0b/%0d",
                             got.rate_bpm, got.rate_updated, got.beat_seen, got.in_pulse,
                             got.interval_ms);
                return;
            end
            want = rates_due.pop_front();
            bad  = 1'b0;
            if (got.rate_bpm !== want.rate_bpm)
                bad = 1'b1;
            if (got.rate_updated !== want.rate_updated)
                bad = 1'b1;
            if (got.beat_seen !== want.beat_seen)
                bad = 1'b1;
            if (got.in_pulse !== want.in_pulse)
                bad = 1'b1;
            if (got.interval_ms !== want.interval_ms)
                bad = 1'b1;
            if (bad)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch at %0t: expected %0d/%0b/%0b/%0b/%0d, got %0d/%0b/%0b/%0b/%0d",
                             $realtime, want.rate_bpm, want.rate_updated, want.beat_seen,
                             want.in_pulse, want.interval_ms, got.rate_bpm, got.rate_updated,
                             got.beat_seen, got.in_pulse, got.interval_ms);
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  wr_en;
    logic [CFG_IDX_W-1:0]  wr_index;
    logic [CFG_DATA_W-1:0] wr_data;

    hbrd_sample_if s_if ();
    hbrd_result_if r_if ();

    rate_scoreboard sb = new();

    // Idle odds in percent for the sample side and the result side.
    int             src_idle_pct;
    int             sink_idle_pct;

    // The main process bumps the request count; the result side serves it with
    // one long stall.
    int             stall_requests = 0;
    int             stall_served = 0;

    int             cycle_count = 0;

    // Configuration the stimulus is shaped for; the scoreboard keeps its own copy.
    detector_cfg_t  cur_cfg;

    heart_beat_rate_detector_unit #(
        .HISTORY_DEPTH (RING_DEPTH)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (s_if),
        .result_ch (r_if),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic detector_cfg_t make_cfg(int thr, int per, int refr, int tmo,
                                               int rmin, int rmax, int dmax);
        detector_cfg_t c;
        c.threshold     = SAMPLE_W'(thr);
        c.period_ms     = PERIOD_W'(per);
        c.refractory_ms = MS_W'(refr);
        c.timeout_ms    = MS_W'(tmo);
        c.rate_min      = RATE_W'(rmin);
        c.rate_max      = RATE_W'(rmax);
        c.double_max    = RATE_W'(dmax);
        return c;
    endfunction

    // A sample strictly below the current threshold, or zero when none exists.
    function automatic logic [SAMPLE_W-1:0] low_sample();
        if (cur_cfg.threshold == 0)
            return '0;
        return SAMPLE_W'($urandom_range(int'(cur_cfg.threshold) - 1, 0));
    endfunction

    // A sample strictly above the current threshold, or full scale when none exists.
    function automatic logic [SAMPLE_W-1:0] high_sample();
        if (cur_cfg.threshold == {SAMPLE_W{1'b1}})
            return {SAMPLE_W{1'b1}};
        return SAMPLE_W'($urandom_range((1 << SAMPLE_W) - 1, int'(cur_cfg.threshold) + 1));
    endfunction

    // Offers one item after a random number of idle cycles and returns at the
    // edge where it is taken. Valid stays high so back-to-back items need no
    // second assignment in the same step.
    task automatic send_sample(input logic [SAMPLE_W-1:0] sample);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_if.valid <= 1'b0;
            @(posedge clk);
        end
        s_if.valid  <= 1'b1;
        s_if.sample <= sample;
        do
            @(posedge clk);
        while (!(s_if.valid && s_if.ready));
        sb.note_sample(sample);
    endtask

    // Stops offering items, waits for every outstanding result and then lets the
    // block settle.
    task automatic wait_drained();
        s_if.valid <= 1'b0;
        while (sb.rates_due.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        sb.write_reg(idx, data);
        @(posedge clk);
    endtask

    // Registers are only rewritten with the block idle, so the scoreboard copy can
    // follow the writes right away.
    task automatic apply_config(input detector_cfg_t c, input bit poke_spare);
        wait_drained();
        put_reg(REG_THRESHOLD, CFG_DATA_W'(c.threshold));
        put_reg(REG_SAMPLE_PERIOD, CFG_DATA_W'(c.period_ms));
        put_reg(REG_REFRACTORY, c.refractory_ms);
        put_reg(REG_TIMEOUT, c.timeout_ms);
        put_reg(REG_RATE_MIN, CFG_DATA_W'(c.rate_min));
        put_reg(REG_RATE_MAX, CFG_DATA_W'(c.rate_max));
        put_reg(REG_DOUBLE_RATE_MAX, CFG_DATA_W'(c.double_max));
        if (poke_spare)
            put_reg(REG_SPARE, {CFG_DATA_W{1'b1}});
        wr_en   <= 1'b0;
        cur_cfg = c;
    endtask

    // Sends a train of heart beats: for each beat a random interval is picked,
    // which gives the number of samples below threshold followed by a short run
    // above it. A few items are replaced by noise or by the threshold value
    // itself, which breaks the train now and then.
    task automatic beat_train(input int n_items, input int min_iv, input int max_iv,
                              input int noise_pct);
        int                  sent;
        int                  iv;
        int                  ticks;
        int                  plen;
        int                  pick;
        logic [SAMPLE_W-1:0] sample;
        sent = 0;
        while (sent < n_items)
        begin
            iv    = $urandom_range(max_iv, min_iv);
            ticks = (cur_cfg.period_ms == 0) ? 2 : iv / int'(cur_cfg.period_ms);
            if (ticks < 2)
                ticks = 2;
            plen = $urandom_range(3, 1);
            if (plen >= ticks)
                plen = ticks - 1;
            for (int k = 0; k < ticks && sent < n_items; k++)
            begin
                pick = $urandom_range(99);
                if (pick < noise_pct)
                    sample = SAMPLE_W'($urandom_range((1 << SAMPLE_W) - 1, 0));
                else if (pick < noise_pct + 2)
                    sample = cur_cfg.threshold;
                else if (k < ticks - plen)
                    sample = low_sample();
                else
                    sample = high_sample();
                send_sample(sample);
                sent++;
            end
        end
    endtask

    // Result side: checks every taken item and drives ready, with one long stall
    // on request so the block fills up and pushes back on the sample side.
    initial
    begin : result_sink
        int           hold;
        rate_result_t got;
        hold        = 0;
        r_if.ready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && r_if.valid && r_if.ready)
            begin
                got.rate_bpm     = r_if.rate_bpm;
                got.rate_updated = r_if.rate_updated;
                got.beat_seen    = r_if.beat_seen;
                got.in_pulse     = r_if.in_pulse;
                got.interval_ms  = r_if.interval_ms;
                sb.check_result(got);
            end
            if (stall_served != stall_requests)
            begin
                stall_served = stall_requests;
                hold = LONG_STALL;
            end
            if (hold > 0)
            begin
                hold--;
                r_if.ready <= 1'b0;
            end
            else
                r_if.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin : stimulus
        detector_cfg_t c;
        rst_n         = 1'b0;
        s_if.valid    = 1'b0;
        s_if.sample   = '0;
        wr_en         = 1'b0;
        wr_index      = '0;
        wr_data       = '0;
        src_idle_pct  = 16;
        sink_idle_pct = 81;
        cur_cfg = make_cfg(int'(THRESHOLD_RESET), int'(PERIOD_RESET),
                           int'(REFRACTORY_RESET), int'(TIMEOUT_RESET),
                           int'(RATE_MIN_RESET), int'(RATE_MAX_RESET),
                           int'(DOUBLE_MAX_RESET));
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values. The clock has barely moved, so none of these can be a
        // beat; they probe the sample extremes and the threshold itself, which
        // neither starts nor ends a pulse.
        send_sample('0);
        send_sample({SAMPLE_W{1'b1}});
        send_sample(12'd2380);
        send_sample(12'd2381);
        send_sample(12'd2379);
        send_sample(12'hAAA);
        send_sample(12'h555);

        // A zero period freezes the clock, and a zero threshold with no
        // refractory window turns the first sample above zero into a beat whose
        // rate is far too high and is dropped. A zero sample cannot end the pulse.
        apply_config(make_cfg(0, 0, 0, 2000, 45, 90, 180), 1'b0);
        send_sample(12'd1);
        send_sample('0);
        send_sample({SAMPLE_W{1'b1}});

        // Full-scale threshold: no sample is above it. A zero timeout clears the
        // history on every tick. The spare register index is written here too.
        apply_config(make_cfg(4095, 255, 65535, 0, 0, 255, 255), 1'b1);
        send_sample({SAMPLE_W{1'b1}});
        send_sample('0);
        send_sample(12'd4094);

        // Every second tick is a beat at 120 per minute; with an empty double
        // band and the widest real band the rates go straight into the history.
        apply_config(make_cfg(2048, 250, 0, 65535, 0, 255, 0), 1'b0);
        repeat (3)
        begin
            send_sample({SAMPLE_W{1'b1}});
            send_sample('0);
        end

        // Beat and timeout on the same tick: the timeout clears the history, so the new rate does not stay.
        apply_config(make_cfg(2048, 250, 0, 400, 0, 255, 0), 1'b0);
        repeat (2)
        begin
            send_sample({SAMPLE_W{1'b1}});
            send_sample('0);
        end

        // Default bands with a faster tick: intervals range from too fast, over
        // the double band and the real band, to slower than the timeout. The
        // result side stalls for a long stretch part of the way in.
        apply_config(make_cfg(2380, 40, 333, 2000, 45, 90, 180), 1'b0);
        beat_train(100, 300, 2400, 8);
        stall_requests <= stall_requests + 1;
        beat_train(200, 300, 2400, 8);

        // Crossed bounds: the real band is empty and only halved rates survive.
        // Halfway the sample side pauses until every result has come back.
        apply_config(make_cfg(1800, 30, 250, 2500, 100, 60, 120), 1'b0);
        beat_train(100, 300, 1500, 8);
        wait_drained();
        beat_train(100, 300, 1500, 8);

        src_idle_pct  = 81;
        sink_idle_pct = 16;

        // Long interval: one beat more than 65535 ms after the last saturates the
        // interval, and its rate comes out as zero, which is dropped although the
        // lowest real rate is zero. Short beats follow.
        apply_config(make_cfg(3000, 255, 1000, 65535, 0, 255, 255), 1'b0);
        beat_train(280, 70000, 70000, 0);
        beat_train(40, 1000, 5000, 5);

        // Many beats in the real band, so the history ring fills and wraps.
        apply_config(make_cfg(2000, 100, 200, 3000, 30, 250, 255), 1'b0);
        beat_train(300, 240, 2000, 5);

        src_idle_pct  = 0;
        sink_idle_pct = 0;

        // Random settings inside plausible ranges.
        repeat (2)
        begin
            c = make_cfg($urandom_range(3500, 500), $urandom_range(200, 50),
                         $urandom_range(400, 0), $urandom_range(65535, 1500),
                         $urandom_range(60, 20), $urandom_range(140, 80),
                         $urandom_range(255, 150));
            apply_config(c, 1'b0);
            beat_train(150, 250, 3000, 10);
        end

        wait_drained();
        if (sb.mismatches == 0 && sb.rates_due.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
